>>> src/avsd_pkg.sv
// ----------------------------------------------------------------------------
// avsd_pkg
// shared types and constants of the avtp stream depacketizer
// ----------------------------------------------------------------------------
package avsd_pkg;

   localparam int CHANNELS_DEFAULT     = 4;
   localparam int HEADER_BYTES_DEFAULT = 14 + 36 + 4;
   localparam int QUEUE_DEPTH          = 4;
   localparam int CH_FIELD_W           = 7;

   localparam logic [15:0] STREAM_ID_BASE_RESET = 16'h3350;

   localparam logic [15:0] OFF_SEQ    = 16'd16;
   localparam logic [15:0] OFF_ID_HI  = 16'd24;
   localparam logic [15:0] OFF_ID_LO  = 16'd25;
   localparam logic [15:0] OFF_LEN_HI = 16'd34;
   localparam logic [15:0] OFF_LEN_LO = 16'd35;
   localparam logic [15:0] OFF_MAX    = 16'hFFFF;

   typedef enum logic [2:0] {
      EV_PAYLOAD     = 3'd0,
      EV_RESYNC      = 3'd1,
      EV_SHORT_FRAME = 3'd2,
      EV_BAD_CHANNEL = 3'd3,
      EV_LENGTH_ERR  = 3'd4
   } event_type;

   typedef enum logic [1:0] {
      OP_PASS,
      OP_CHECK,
      OP_DATA
   } op_type;

   typedef struct packed {
      op_type                  op;
      event_type               kind;
      logic [CH_FIELD_W-1:0]   channel;
      logic [7:0]              data;
      logic                    last;
      logic [7:0]              seq;
      logic                    len_ok;
      logic                    fwd;
   } item_type;

endpackage

>>> src/avsd_front.sv
// ----------------------------------------------------------------------------
// avsd_front
// byte parser: tracks the frame offset, captures header fields, maps the
// stream id to a channel and queues classified transactions
// ----------------------------------------------------------------------------
module avsd_front #(
   parameter int CHANNELS     = avsd_pkg::CHANNELS_DEFAULT,
   parameter int HEADER_BYTES = avsd_pkg::HEADER_BYTES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_frame_byte,
   input  logic                req_frame_start,
   input  logic [15:0]         req_frame_length,
   input  logic [15:0]         stream_id_base,
   input  logic                q_full,
   output logic                q_push,
   output avsd_pkg::item_type  q_item
);

   localparam logic [15:0] HB = 16'(HEADER_BYTES);

   logic [15:0] off_ff, off_in;
   logic        active_ff, active_in;
   logic        fwd_ff, fwd_in;
   logic [7:0]  seq_ff, seq_in;
   logic [15:0] id_ff, id_in;
   logic [7:0]  len_hi_ff, len_hi_in;
   logic [avsd_pkg::CH_FIELD_W-1:0] ch_ff, ch_in;
   logic [16:0] last_off_ff, last_off_in;

   logic        accept;
   logic [15:0] off_step;
   logic [16:0] diff;
   logic [15:0] plen;
   logic [16:0] len_need;
   logic        len_ok;
   logic        bad_ch;

   assign req_ready = !q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      off_step = req_frame_start ? 16'd0
               : (off_ff != avsd_pkg::OFF_MAX) ? off_ff + 16'd1 : off_ff;
      diff     = {1'b0, id_ff} - {1'b0, stream_id_base} - 17'd1;
      plen     = {len_hi_ff, req_frame_byte};
      len_need = {1'b0, HB} + {1'b0, plen};
      len_ok   = {1'b0, req_frame_length} >= len_need;
      bad_ch   = diff[16] || (diff[15:1] >= 15'(CHANNELS));

      off_in      = off_ff;
      active_in   = active_ff;
      fwd_in      = fwd_ff;
      seq_in      = seq_ff;
      id_in       = id_ff;
      len_hi_in   = len_hi_ff;
      ch_in       = ch_ff;
      last_off_in = last_off_ff;
      q_push      = 1'b0;
      q_item      = avsd_pkg::item_type'('0);

      if (accept) begin
         off_in = off_step;
         if (req_frame_start) begin
            seq_in    = 8'd0;
            id_in     = 16'd0;
            len_hi_in = 8'd0;
            fwd_in    = 1'b0;
            ch_in     = '0;
            if (req_frame_length <= HB) begin
               active_in   = 1'b0;
               q_push      = 1'b1;
               q_item.op   = avsd_pkg::OP_PASS;
               q_item.kind = avsd_pkg::EV_SHORT_FRAME;
            end else begin
               active_in = 1'b1;
            end
         end else if (active_ff) begin
            case (off_step)
               avsd_pkg::OFF_SEQ:    seq_in = req_frame_byte;
               avsd_pkg::OFF_ID_HI:  id_in = {req_frame_byte, id_ff[7:0]};
               avsd_pkg::OFF_ID_LO:  id_in = {id_ff[15:8], req_frame_byte};
               avsd_pkg::OFF_LEN_HI: len_hi_in = req_frame_byte;
               avsd_pkg::OFF_LEN_LO: begin
                  q_push = 1'b1;
                  if (bad_ch) begin
                     active_in   = 1'b0;
                     q_item.op   = avsd_pkg::OP_PASS;
                     q_item.kind = avsd_pkg::EV_BAD_CHANNEL;
                     q_item.seq  = seq_ff;
                  end else begin
                     q_item.op      = avsd_pkg::OP_CHECK;
                     q_item.channel = diff[avsd_pkg::CH_FIELD_W:1];
                     q_item.seq     = seq_ff;
                     q_item.len_ok  = len_ok;
                     q_item.fwd     = plen != 16'd0;
                     ch_in          = diff[avsd_pkg::CH_FIELD_W:1];
                     last_off_in    = len_need - 17'd1;
                     if (!len_ok || plen == 16'd0) begin
                        active_in = 1'b0;
                     end else begin
                        fwd_in = 1'b1;
                     end
                  end
               end
               default: begin
                  if (fwd_ff && off_step >= HB) begin
                     q_push         = 1'b1;
                     q_item.op      = avsd_pkg::OP_DATA;
                     q_item.kind    = avsd_pkg::EV_PAYLOAD;
                     q_item.channel = ch_ff;
                     q_item.data    = req_frame_byte;
                     q_item.seq     = seq_ff;
                     q_item.last    = {1'b0, off_step} == last_off_ff;
                     if ({1'b0, off_step} == last_off_ff) begin
                        fwd_in    = 1'b0;
                        active_in = 1'b0;
                     end
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff      <= 16'd0;
         active_ff   <= 1'b0;
         fwd_ff      <= 1'b0;
         seq_ff      <= 8'd0;
         id_ff       <= 16'd0;
         len_hi_ff   <= 8'd0;
         ch_ff       <= '0;
         last_off_ff <= 17'd0;
      end else begin
         off_ff      <= off_in;
         active_ff   <= active_in;
         fwd_ff      <= fwd_in;
         seq_ff      <= seq_in;
         id_ff       <= id_in;
         len_hi_ff   <= len_hi_in;
         ch_ff       <= ch_in;
         last_off_ff <= last_off_in;
      end
   end

endmodule

>>> src/avsd_queue.sv
// ----------------------------------------------------------------------------
// avsd_queue
// short shifting queue between parser and sequence checker
// ----------------------------------------------------------------------------
module avsd_queue #(
   parameter int DEPTH = avsd_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  avsd_pkg::item_type  push_item,
   output logic                full,
   input  logic                pop,
   output avsd_pkg::item_type  head_item,
   output logic                empty
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   avsd_pkg::item_type slot_ff [DEPTH];
   avsd_pkg::item_type slot_in [DEPTH];
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   wr_idx;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign empty     = count_ff == '0;
   assign head_item = slot_ff[0];

   always_comb begin
      wr_idx   = count_ff - (pop ? CNT_W'(1) : CNT_W'(0));
      count_in = count_ff + (push ? CNT_W'(1) : CNT_W'(0))
                          - (pop ? CNT_W'(1) : CNT_W'(0));
      for (int i = 0; i < DEPTH; i++) begin
         if (pop && i < DEPTH - 1) begin
            slot_in[i] = slot_ff[i + 1];
         end else begin
            slot_in[i] = slot_ff[i];
         end
         if (push && wr_idx == CNT_W'(i)) begin
            slot_in[i] = push_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

endmodule

>>> src/avsd_back.sv
// ----------------------------------------------------------------------------
// avsd_back
// per-channel sequence check, frame drop decision and result register
// ----------------------------------------------------------------------------
module avsd_back #(
   parameter int CHANNELS = avsd_pkg::CHANNELS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  avsd_pkg::item_type  q_item,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_event_kind,
   output logic [1:0]          rsp_channel_index,
   output logic [7:0]          rsp_payload_byte,
   output logic                rsp_payload_last,
   output logic [7:0]          rsp_sequence_seen
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [7:0]          seq_mem [CHANNELS];
   logic [CHANNELS-1:0] valid_ff;

   avsd_pkg::item_type  s2_ff;
   logic                s2_v_ff, s2_v_in;
   logic [7:0]          rd_seq_ff;
   logic                rd_valid_ff;
   logic                pass_ff, pass_in;

   logic                out_v_ff, out_v_in;
   avsd_pkg::event_type out_kind_ff, out_kind_in;
   logic [1:0]          out_ch_ff, out_ch_in;
   logic [7:0]          out_byte_ff, out_byte_in;
   logic                out_last_ff, out_last_in;
   logic [7:0]          out_seq_ff, out_seq_in;

   logic                out_free;
   logic                gap;
   logic                emit;
   avsd_pkg::event_type ekind;
   logic                done;
   logic                wr_en;
   logic [CH_W-1:0]     wr_addr;
   logic [CH_W-1:0]     rd_addr;
   logic                bypass;

   always_comb begin
      out_free = !out_v_ff || rsp_ready;
      gap      = rd_valid_ff && (s2_ff.seq != rd_seq_ff + 8'd1);
      emit     = 1'b0;
      ekind    = s2_ff.kind;
      unique case (s2_ff.op)
         avsd_pkg::OP_PASS: emit = 1'b1;
         avsd_pkg::OP_CHECK: begin
            emit  = gap || !s2_ff.len_ok;
            ekind = gap ? avsd_pkg::EV_RESYNC : avsd_pkg::EV_LENGTH_ERR;
         end
         avsd_pkg::OP_DATA: begin
            emit  = pass_ff;
            ekind = avsd_pkg::EV_PAYLOAD;
         end
         default: emit = 1'b0;
      endcase

      done    = s2_v_ff && (!emit || out_free);
      q_pop   = !q_empty && (!s2_v_ff || done);
      wr_en   = done && s2_ff.op == avsd_pkg::OP_CHECK;
      wr_addr = s2_ff.channel[CH_W-1:0];
      rd_addr = q_item.channel[CH_W-1:0];
      bypass  = wr_en && wr_addr == rd_addr;

      s2_v_in = q_pop ? 1'b1 : (done ? 1'b0 : s2_v_ff);

      pass_in = pass_ff;
      if (wr_en) begin
         pass_in = !gap && s2_ff.len_ok && s2_ff.fwd;
      end else if (done && s2_ff.op == avsd_pkg::OP_DATA && s2_ff.last) begin
         pass_in = 1'b0;
      end

      out_v_in    = out_v_ff && !rsp_ready;
      out_kind_in = out_kind_ff;
      out_ch_in   = out_ch_ff;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      out_seq_in  = out_seq_ff;
      if (done && emit) begin
         out_v_in    = 1'b1;
         out_kind_in = ekind;
         out_ch_in   = s2_ff.channel[1:0];
         out_byte_in = (s2_ff.op == avsd_pkg::OP_CHECK) ? 8'd0 : s2_ff.data;
         out_last_in = (s2_ff.op == avsd_pkg::OP_CHECK) ? 1'b0 : s2_ff.last;
         out_seq_in  = s2_ff.seq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff  <= 1'b0;
         pass_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         valid_ff <= '0;
      end else begin
         s2_v_ff  <= s2_v_in;
         pass_ff  <= pass_in;
         out_v_ff <= out_v_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         seq_mem[wr_addr] <= s2_ff.seq;
      end
      if (q_pop) begin
         s2_ff       <= q_item;
         rd_seq_ff   <= bypass ? s2_ff.seq : seq_mem[rd_addr];
         rd_valid_ff <= bypass ? 1'b1 : valid_ff[rd_addr];
      end
      out_kind_ff <= out_kind_in;
      out_ch_ff   <= out_ch_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_seq_ff  <= out_seq_in;
   end

   assign rsp_valid         = out_v_ff;
   assign rsp_event_kind    = out_kind_ff;
   assign rsp_channel_index = out_ch_ff;
   assign rsp_payload_byte  = out_byte_ff;
   assign rsp_payload_last  = out_last_ff;
   assign rsp_sequence_seen = out_seq_ff;

endmodule

>>> src/avtp_stream_depacketizer.sv
// ----------------------------------------------------------------------------
// avtp_stream_depacketizer
// ieee 1722 avtp stream depacketizer with per-channel sequence tracking
// ----------------------------------------------------------------------------
// usage
//   req_* takes one ethernet frame byte per transaction; req_frame_start marks
//   offset 0 and req_frame_length gives the frame size. rsp_* delivers one
//   transaction per payload byte (offset HEADER_BYTES on) or per event:
//   decoder resync, short frame, bad channel or length error.
//   csr_write_enable/csr_write_data load the stream id base; write only idle.
//   throughput is one byte per cycle while req_ready is high. the byte is
//   classified as it is accepted and lands in a queue slot, the checker stage
//   takes it with the registered sequence memory read, then it moves to the
//   output register, which drives rsp_valid.
//   when the receiver stalls, the output register holds, the checker stage
//   and the 4-entry queue absorb further bytes and req_ready drops only when
//   the queue is full.
//   reset is synchronous; it clears all sequence state (every channel starts
//   unset), the parser and the queue, and restores the stream id base.
// ----------------------------------------------------------------------------
module avtp_stream_depacketizer #(
   parameter int CHANNELS     = avsd_pkg::CHANNELS_DEFAULT,
   parameter int HEADER_BYTES = avsd_pkg::HEADER_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_frame_start,
   input  logic [15:0] req_frame_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_kind,
   output logic [1:0]  rsp_channel_index,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_payload_last,
   output logic [7:0]  rsp_sequence_seen,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   logic [15:0]        base_ff;
   logic               q_push;
   logic               q_pop;
   logic               q_full;
   logic               q_empty;
   avsd_pkg::item_type push_item;
   avsd_pkg::item_type head_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= avsd_pkg::STREAM_ID_BASE_RESET;
      end else if (csr_write_enable) begin
         base_ff <= csr_write_data;
      end
   end

   avsd_front #(
      .CHANNELS     (CHANNELS),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_frame_byte   (req_frame_byte),
      .req_frame_start  (req_frame_start),
      .req_frame_length (req_frame_length),
      .stream_id_base   (base_ff),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_item           (push_item)
   );

   avsd_queue #(
      .DEPTH (avsd_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .head_item (head_item),
      .empty     (q_empty)
   );

   avsd_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_item            (head_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_channel_index (rsp_channel_index),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_last  (rsp_payload_last),
      .rsp_sequence_seen (rsp_sequence_seen)
   );

   a_queue_sane : assert property (@(posedge clock) disable iff (reset)
      !(q_full && q_empty))
      else $error("queue full and empty together");

   a_short_queued : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_frame_start
         && req_frame_length <= 16'(HEADER_BYTES) |=> !q_empty)
      else $error("short frame event not queued");

   a_last_only_payload : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind != avsd_pkg::EV_PAYLOAD |-> !rsp_payload_last)
      else $error("last flag on an event");

   a_short_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == avsd_pkg::EV_SHORT_FRAME
         |-> rsp_sequence_seen == 8'd0 && rsp_channel_index == 2'd0)
      else $error("short frame reports captured fields");

endmodule

>>> tb/sv/avtp_stream_depacketizer_tb.sv
// ----------------------------------------------------------------------------
// avtp_stream_depacketizer_tb
// self-checking regression for the avtp stream depacketizer: frames are built
// byte by byte with chosen stream ids, sequence numbers and payload lengths,
// every accepted byte runs through a behavioral parser in the bench, and each
// response transaction is compared field by field against the oldest
// predicted event. both handshakes idle at random and the stream id base is
// reprogrammed between phases while the block is idle.
// ----------------------------------------------------------------------------
module avtp_stream_depacketizer_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HDR           = avsd_pkg::HEADER_BYTES_DEFAULT;
   localparam int NCH           = avsd_pkg::CHANNELS_DEFAULT;
   localparam int SETTLE_CYCLES = 12;
   localparam int IDLE_MAX      = 10;
   localparam int TIMEOUT_NS    = 20_000_000;

   typedef enum {ENT_BYTE, ENT_CONFIG, ENT_DRAIN, ENT_PACE} entry_kind;

   typedef struct {
      entry_kind   kind;
      logic [7:0]  data;
      logic        start;
      logic [15:0] flen;
      int          value;
   } pending_entry;

   typedef struct {
      avsd_pkg::event_type kind;
      logic [1:0]          channel;
      logic [7:0]          data;
      logic                last;
      logic [7:0]          seq;
   } depkt_event;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_frame_byte = 8'h00;
   logic        req_frame_start = 1'b0;
   logic [15:0] req_frame_length = 16'h0000;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_event_kind;
   logic [1:0]  rsp_channel_index;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_payload_last;
   logic [7:0]  rsp_sequence_seen;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = 16'h0000;

   avtp_stream_depacketizer u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_frame_byte    (req_frame_byte),
      .req_frame_start   (req_frame_start),
      .req_frame_length  (req_frame_length),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_channel_index (rsp_channel_index),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_last  (rsp_payload_last),
      .rsp_sequence_seen (rsp_sequence_seen),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // stimulus and scoreboard storage
   pending_entry pending_bytes[$];
   depkt_event   expected_events[$];

   int  idle_max = IDLE_MAX;
   int  gap_left = 0;
   int  stall_left = 0;
   int  quiet = 0;
   bit  req_accepted = 1'b0;
   bit  rsp_taken = 1'b0;
   int  error_count = 0;
   int  items_accepted = 0;
   int  results_checked = 0;
   int  config_writes = 0;
   int  frames_built = 0;
   int  kind_count[5];

   // parser state of the bench
   logic [15:0] id_base = avsd_pkg::STREAM_ID_BASE_RESET;
   logic        seq_known[NCH];
   logic [7:0]  seq_prev[NCH];
   logic [15:0] dp_offset = '0;
   logic [7:0]  dp_seq = '0;
   logic [15:0] dp_id = '0;
   logic [15:0] dp_len = '0;
   logic        dp_fwd = 1'b0;
   logic [1:0]  dp_channel = '0;
   logic        dp_active = 1'b0;

   // generator shadow
   logic [15:0] gen_base = avsd_pkg::STREAM_ID_BASE_RESET;
   logic [7:0]  gen_next[NCH];
   int          gen_items = 0;

   function automatic int draw_idle();
      return (idle_max == 0) ? 0 : $urandom_range(idle_max, 0);
   endfunction

   function automatic void push_event(avsd_pkg::event_type k, logic [1:0] ch,
                                      logic [7:0] d, logic l, logic [7:0] s);
      expected_events.push_back('{k, ch, d, l, s});
   endfunction

   function automatic void depacketize_byte(logic [7:0] data, logic start,
                                            logic [15:0] flen);
      int          dist_id;
      int          ch;
      logic [7:0]  nxt;
      if (start) begin
         dp_offset = '0;
         dp_fwd = 1'b0;
         dp_channel = '0;
         dp_seq = '0;
         dp_id = '0;
         dp_len = '0;
         if (int'(flen) <= HDR) begin
            dp_active = 1'b0;
            push_event(avsd_pkg::EV_SHORT_FRAME, 2'd0, 8'd0, 1'b0, 8'd0);
            return;
         end
         dp_active = 1'b1;
      end else if (dp_offset != avsd_pkg::OFF_MAX) begin
         dp_offset = dp_offset + 16'd1;
      end
      if (!dp_active)
         return;
      if (dp_offset == avsd_pkg::OFF_SEQ) begin
         dp_seq = data;
      end else if (dp_offset == avsd_pkg::OFF_ID_HI) begin
         dp_id[15:8] = data;
      end else if (dp_offset == avsd_pkg::OFF_ID_LO) begin
         dp_id[7:0] = data;
      end else if (dp_offset == avsd_pkg::OFF_LEN_HI) begin
         dp_len[15:8] = data;
      end else if (dp_offset == avsd_pkg::OFF_LEN_LO) begin
         dp_len[7:0] = data;
         dist_id = int'(dp_id) - int'(id_base) - 1;
         if (dist_id < 0 || (dist_id / 2) >= NCH) begin
            dp_active = 1'b0;
            push_event(avsd_pkg::EV_BAD_CHANNEL, 2'd0, 8'd0, 1'b0, dp_seq);
            return;
         end
         ch = dist_id / 2;
         dp_channel = 2'(ch);
         nxt = seq_prev[ch] + 8'd1;
         if (seq_known[ch] && dp_seq != nxt) begin
            seq_prev[ch] = dp_seq;
            dp_active = 1'b0;
            push_event(avsd_pkg::EV_RESYNC, dp_channel, 8'd0, 1'b0, dp_seq);
            return;
         end
         seq_known[ch] = 1'b1;
         seq_prev[ch] = dp_seq;
         if (int'(flen) < HDR + int'(dp_len)) begin
            dp_active = 1'b0;
            push_event(avsd_pkg::EV_LENGTH_ERR, dp_channel, 8'd0, 1'b0, dp_seq);
            return;
         end
         dp_fwd = (dp_len != 16'd0);
         if (!dp_fwd)
            dp_active = 1'b0;
      end else if (dp_fwd && int'(dp_offset) >= HDR) begin
         if (int'(dp_offset) == HDR + int'(dp_len) - 1) begin
            dp_fwd = 1'b0;
            dp_active = 1'b0;
            push_event(avsd_pkg::EV_PAYLOAD, dp_channel, data, 1'b1, dp_seq);
         end else begin
            push_event(avsd_pkg::EV_PAYLOAD, dp_channel, data, 1'b0, dp_seq);
         end
      end
   endfunction

   function automatic void check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         error_count++;
      end
   endfunction

   // monitor: sample both channels at the rising edge
   always @(posedge clock) begin : monitor
      depkt_event exp_ev;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_taken = 1'b1;
            results_checked++;
            if (rsp_event_kind < 3'd5)
               kind_count[rsp_event_kind]++;
            if (expected_events.size() == 0) begin
               $error("response transaction with no event expected (kind %0d)",
                      rsp_event_kind);
               error_count++;
            end else begin
               exp_ev = expected_events.pop_front();
               check_field("event_kind", int'(exp_ev.kind), int'(rsp_event_kind));
               check_field("channel_index", exp_ev.channel, rsp_channel_index);
               check_field("payload_byte", exp_ev.data, rsp_payload_byte);
               check_field("payload_last", exp_ev.last, rsp_payload_last);
               check_field("sequence_seen", exp_ev.seq, rsp_sequence_seen);
            end
         end
         if (req_valid && req_ready) begin
            depacketize_byte(req_frame_byte, req_frame_start, req_frame_length);
            req_accepted = 1'b1;
            items_accepted++;
         end
      end
   end

   // driver: request channel and register writes at the falling edge
   always @(negedge clock) begin : sender
      logic         nv;
      logic [7:0]   nd;
      logic         ns;
      logic [15:0]  nl;
      logic         wr;
      logic [15:0]  wd;
      pending_entry ent;
      nv = req_valid;
      nd = req_frame_byte;
      ns = req_frame_start;
      nl = req_frame_length;
      wr = 1'b0;
      wd = csr_write_data;
      if (req_accepted) begin
         nv = 1'b0;
         req_accepted = 1'b0;
      end
      if (!nv && expected_events.size() == 0)
         quiet++;
      else
         quiet = 0;
      if (!reset && !nv) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_bytes.size() > 0) begin
            ent = pending_bytes[0];
            case (ent.kind)
               ENT_BYTE: begin
                  nv = 1'b1;
                  nd = ent.data;
                  ns = ent.start;
                  nl = ent.flen;
                  void'(pending_bytes.pop_front());
                  gap_left = draw_idle();
               end
               ENT_PACE: begin
                  idle_max = ent.value;
                  void'(pending_bytes.pop_front());
               end
               default: begin
                  if (quiet >= SETTLE_CYCLES) begin
                     if (ent.kind == ENT_CONFIG) begin
                        wr = 1'b1;
                        wd = 16'(ent.value);
                        id_base = 16'(ent.value);
                        config_writes++;
                     end
                     void'(pending_bytes.pop_front());
                     quiet = 0;
                  end
               end
            endcase
         end
      end
      req_valid <= nv;
      req_frame_byte <= nd;
      req_frame_start <= ns;
      req_frame_length <= nl;
      csr_write_enable <= wr;
      csr_write_data <= wd;
   end

   // receiver: backpressure on the response channel
   always @(negedge clock) begin : receiver
      if (rsp_taken) begin
         rsp_taken = 1'b0;
         stall_left = draw_idle();
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic push_byte(logic [7:0] d, logic s, logic [15:0] fl);
      pending_bytes.push_back('{ENT_BYTE, d, s, fl, 0});
      gen_items++;
   endtask

   task automatic push_ctrl(entry_kind k, int v);
      pending_bytes.push_back('{k, 8'd0, 1'b0, 16'd0, v});
   endtask

   task automatic push_config(logic [15:0] b);
      push_ctrl(ENT_CONFIG, int'(b));
      gen_base = b;
   endtask

   function automatic logic [15:0] chan_id(int ch, int odd);
      return gen_base + 16'(1 + 2 * ch + odd);
   endfunction

   task automatic push_frame(logic [15:0] id, logic [7:0] seq, logic [15:0] plen,
                             logic [15:0] flen, int nbytes);
      logic [7:0] d;
      int         dist_id;
      for (int i = 0; i < nbytes; i++) begin
         d = 8'($urandom);
         if (i == int'(avsd_pkg::OFF_SEQ))
            d = seq;
         else if (i == int'(avsd_pkg::OFF_ID_HI))
            d = id[15:8];
         else if (i == int'(avsd_pkg::OFF_ID_LO))
            d = id[7:0];
         else if (i == int'(avsd_pkg::OFF_LEN_HI))
            d = plen[15:8];
         else if (i == int'(avsd_pkg::OFF_LEN_LO))
            d = plen[7:0];
         push_byte(d, i == 0, flen);
      end
      frames_built++;
      dist_id = int'(id) - int'(gen_base) - 1;
      if (nbytes > int'(avsd_pkg::OFF_LEN_LO) && int'(flen) > HDR && dist_id >= 0 &&
          dist_id / 2 < NCH)
         gen_next[dist_id / 2] = seq + 8'd1;
   endtask

   task automatic random_frame();
      int          ch;
      int          sel;
      int          plen;
      int          flen;
      int          nbytes;
      logic [15:0] id;
      logic [7:0]  seq;
      sel = $urandom_range(15, 0);
      if (sel == 0)
         push_ctrl(ENT_PACE, 0);
      else if (sel == 1)
         push_ctrl(ENT_PACE, IDLE_MAX);
      else if (sel == 2)
         push_ctrl(ENT_DRAIN, 0);
      ch = $urandom_range(NCH - 1, 0);
      id = chan_id(ch, $urandom_range(1, 0));
      sel = $urandom_range(99, 0);
      if (sel < 3)
         id = gen_base;
      else if (sel < 6)
         id = gen_base - 16'($urandom_range(300, 1));
      else if (sel < 9)
         id = gen_base + 16'($urandom_range(300, 2 * NCH + 1));
      else if (sel < 11)
         id = 16'($urandom);
      seq = ($urandom_range(9, 0) == 0) ? 8'($urandom) : gen_next[ch];
      plen = ($urandom_range(9, 0) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 0);
      flen = HDR + plen;
      nbytes = HDR + plen + $urandom_range(2, 0);
      sel = $urandom_range(99, 0);
      if (sel < 10) begin
         flen = $urandom_range(65535, HDR + plen);
      end else if (sel < 16) begin
         plen = $urandom_range(40, 2);
         flen = $urandom_range(HDR + plen - 1, HDR + 1);
         nbytes = int'(avsd_pkg::OFF_LEN_LO) + 1 + $urandom_range(4, 0);
      end else if (sel < 20) begin
         plen = int'(16'($urandom) | 16'h8000);
         flen = $urandom_range(32767, HDR + 1);
         nbytes = int'(avsd_pkg::OFF_LEN_LO) + 1 + $urandom_range(4, 0);
      end else if (sel < 26) begin
         flen = $urandom_range(HDR, 0);
         nbytes = $urandom_range(8, 1);
      end else if (sel < 33) begin
         nbytes = $urandom_range(HDR + plen - 1, 1);
      end
      push_frame(id, seq, 16'(plen), 16'(flen), nbytes);
   endtask

   initial begin : main
      int          target;
      logic [15:0] b;
      for (int c = 0; c < NCH; c++) begin
         seq_known[c] = 1'b0;
         seq_prev[c] = 8'd0;
         gen_next[c] = 8'($urandom);
      end
      for (int k = 0; k < 5; k++)
         kind_count[k] = 0;

      // directed cases, reset base
      for (int i = 0; i < 3; i++)
         push_byte(8'($urandom), 1'b0, 16'($urandom));
      push_frame(chan_id(0, 0), 8'h11, 16'd3, 16'(HDR), 4);
      push_frame(chan_id(0, 0), 8'h11, 16'd3, 16'd0, 1);
      push_frame(chan_id(0, 0), 8'h05, 16'd3, 16'(HDR + 3), HDR + 3);
      push_frame(gen_base, 8'h33, 16'd3, 16'(HDR + 3), HDR + 3);
      push_frame(chan_id(NCH, 0), 8'h34, 16'd3, 16'(HDR + 3), HDR + 3);
      push_frame(chan_id(3, 1), 8'hFF, 16'd1, 16'(HDR + 1), HDR + 1);
      push_frame(chan_id(3, 0), 8'h00, 16'd2, 16'(HDR + 2), HDR + 2);
      push_frame(chan_id(0, 1), 8'h06, 16'd0, 16'd60, 40);
      push_frame(chan_id(0, 0), 8'h09, 16'd4, 16'(HDR + 4), HDR + 4);
      push_frame(chan_id(0, 0), 8'h0A, 16'd4, 16'(HDR + 3), HDR + 4);
      push_frame(chan_id(1, 0), 8'h80, 16'd5, 16'hFFFF, HDR + 7);
      push_frame(chan_id(2, 0), 8'h01, 16'd6, 16'(HDR + 6), HDR + 3);
      push_frame(chan_id(2, 1), 8'h4D, 16'd6, 16'(HDR + 6), 20);
      push_frame(chan_id(2, 0), 8'h02, 16'd2, 16'(HDR + 2), HDR + 2);
      push_ctrl(ENT_DRAIN, 0);

      // random phases across stream id bases
      target = gen_items;
      for (int p = 0; p < 6; p++) begin
         if (p > 0) begin
            case (p)
               1: b = 16'h0000;
               2: b = 16'($urandom);
               3: b = 16'hFFF8;
               4: b = 16'hFFFF;
               default: b = avsd_pkg::STREAM_ID_BASE_RESET;
            endcase
            push_ctrl(ENT_PACE, IDLE_MAX);
            push_config(b);
         end
         target += (p == 4) ? 50 : 160;
         while (gen_items < target)
            random_frame();
      end

      // long payload frame without idling
      push_ctrl(ENT_DRAIN, 0);
      push_ctrl(ENT_PACE, 0);
      push_frame(chan_id(1, 1), gen_next[1], 16'd40, 16'(HDR + 40), HDR + 40);
      push_ctrl(ENT_PACE, IDLE_MAX);
      push_frame(chan_id(1, 0), gen_next[1], 16'd2, 16'(HDR + 2), HDR + 2);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_valid || expected_events.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d frames, %0d bytes accepted, %0d config writes, %0d responses checked",
               frames_built, items_accepted, config_writes, results_checked);
      $display("payload %0d, resync %0d, short %0d, bad channel %0d, length error %0d",
               kind_count[0], kind_count[1], kind_count[2], kind_count[3], kind_count[4]);
      if (error_count == 0 && expected_events.size() == 0) begin
         $display("avtp_stream_depacketizer regression: pass");
      end else begin
         $display("avtp_stream_depacketizer regression: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("avtp_stream_depacketizer regression: fail");
      $finish;
   end

endmodule
